// File: rtl/nmf_pkg.sv
package nmf_pkg;

    // frame limits
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 32;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    // pending count reaches frame width + 2 before the emit takes one away
    localparam int PEND_W   = $clog2(MAX_COLS + 3);

    // field widths
    localparam int FW_W      = 8;
    localparam int FH_W      = 6;
    localparam int CODE_W    = 8;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    // register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0] FW_RESET = 8'd80;
    localparam logic [FH_W-1:0] FH_RESET = 6'd21;
    localparam int FRAME_MIN = 3;

    // word commands
    localparam logic CMD_CELL = 1'b0;

    // class codes, in tie-break order
    localparam logic [CODE_W-1:0] CLS_SAND  = 8'h2E;  // '.'
    localparam logic [CODE_W-1:0] CLS_GRASS = 8'h3A;  // ':'
    localparam logic [CODE_W-1:0] CLS_WATER = 8'h7E;  // '~'
    localparam logic [CODE_W-1:0] CLS_ROCK  = 8'h26;  // '&'

    // job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // which neighbours of the emitted cell may be counted
    typedef struct packed {
        logic interior;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_nbr_flags;

    // one emit job: new window column, center cell, position, frame end and neighbour flags
    typedef struct packed {
        logic [CODE_W-1:0] top;
        logic [CODE_W-1:0] mid;
        logic [CODE_W-1:0] bot;
        logic [CODE_W-1:0] center;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              frame_end;
        t_nbr_flags        flags;
    } t_job;

endpackage

// File: rtl/nmf_front.sv
module nmf_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic [nmf_pkg::FW_W-1:0] i_frame_width,
    input  logic [nmf_pkg::FH_W-1:0] i_frame_height,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_command,
    input  logic [7:0]               i_cell_code,
    input  logic [nmf_pkg::QCNT_W-1:0] i_q_count,
    output logic                     o_push,
    output nmf_pkg::t_job            o_job
);
    import nmf_pkg::*;

    localparam int CW1 = COL_W + 1;
    localparam int RW1 = ROW_W + 1;

    function automatic logic [1:0] inc3(input logic [1:0] m);
        logic [1:0] r;
        r = (m == 2'd2) ? 2'd0 : m + 2'd1;
        return r;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] m);
        logic [1:0] r;
        r = (m == 2'd0) ? 2'd2 : m - 2'd1;
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] sel3(input logic [CODE_W-1:0] a,
                                                input logic [CODE_W-1:0] b,
                                                input logic [CODE_W-1:0] c,
                                                input logic [1:0] s);
        logic [CODE_W-1:0] r;
        unique case (s)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    // frame position state
    logic [COL_W-1:0]  r_icol, n_icol;
    logic [ROW_W-1:0]  r_irow, n_irow;
    logic [1:0]        r_im3, n_im3;
    logic [COL_W-1:0]  r_ecol, n_ecol;
    logic [ROW_W-1:0]  r_erow, n_erow;
    logic [1:0]        r_em3, n_em3;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_done, n_done;

    // read stage
    logic              r_s1_valid;
    logic [1:0]        r_s1_m3;
    logic              r_s1_byp;
    logic [CODE_W-1:0] r_s1_code;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_end;
    t_nbr_flags        r_s1_flags;

    logic [CODE_W-1:0] r_rd_nxt [3];
    logic [CODE_W-1:0] r_rd_ctr [3];

    logic              w_accept, w_write, w_emit;
    logic [PEND_W-1:0] w_pend_inc, w_pend_lim;
    logic [CW1-1:0]    w_w;
    logic [RW1-1:0]    w_h;
    logic              w_e_last_col, w_e_last_row, w_frame_end;
    logic              w_i_last_col, w_i_last_row;
    logic [COL_W-1:0]  w_rd_col;
    t_nbr_flags        w_flags;

    // room in the queue for everything already in flight
    assign o_in_ready = ((QCNT_W + 1)'(i_q_count) + (QCNT_W + 1)'(r_s1_valid))
                        < (QCNT_W + 1)'(Q_DEPTH);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_w = CW1'(i_frame_width);
    assign w_h = RW1'(i_frame_height);

    // a cell word after the frame is complete counts as flush
    assign w_write    = (i_command == CMD_CELL) && !r_done;
    assign w_pend_inc = r_pend + PEND_W'(1);
    assign w_pend_lim = PEND_W'(i_frame_width) + PEND_W'(1);
    assign w_emit     = w_write ? (w_pend_inc > w_pend_lim) : (r_done && (r_pend != '0));

    assign w_e_last_col = (CW1'(r_ecol) + CW1'(1)) == w_w;
    assign w_e_last_row = (RW1'(r_erow) + RW1'(1)) == w_h;
    assign w_frame_end  = w_e_last_col && w_e_last_row;
    assign w_i_last_col = (CW1'(r_icol) + CW1'(1)) == w_w;
    assign w_i_last_row = (RW1'(r_irow) + RW1'(1)) == w_h;

    // column right of the emitted cell feeds the window
    assign w_rd_col = r_ecol + COL_W'(1);

    // border neighbours are not counted
    assign w_flags.interior = (r_erow != '0) && (r_ecol != '0) && !w_e_last_row && !w_e_last_col;
    assign w_flags.top_ok   = r_erow != ROW_W'(1);
    assign w_flags.bot_ok   = (RW1'(r_erow) + RW1'(2)) != w_h;
    assign w_flags.left_ok  = r_ecol != COL_W'(1);
    assign w_flags.right_ok = (CW1'(r_ecol) + CW1'(2)) != w_w;

    // three-row rolling line store, one bank per row mod 3
    for (genvar g = 0; g < 3; g++) begin : g_bank
        logic [CODE_W-1:0] r_mem [MAX_COLS];

        always_ff @(posedge i_clk) begin
            if (w_accept && w_write && (r_im3 == 2'(g))) begin
                r_mem[r_icol] <= i_cell_code;
            end
            if (w_accept && w_emit) begin
                r_rd_nxt[g] <= r_mem[w_rd_col];
                r_rd_ctr[g] <= r_mem[r_ecol];
            end
        end
    end

    // next position state
    always_comb begin
        n_icol = r_icol;
        n_irow = r_irow;
        n_im3  = r_im3;
        n_ecol = r_ecol;
        n_erow = r_erow;
        n_em3  = r_em3;
        n_pend = r_pend;
        n_done = r_done;
        priority if (i_restart || (w_accept && w_emit && w_frame_end)) begin
            n_icol = '0;
            n_irow = '0;
            n_im3  = '0;
            n_ecol = '0;
            n_erow = '0;
            n_em3  = '0;
            n_pend = '0;
            n_done = 1'b0;
        end else if (w_accept) begin
            if (w_write) begin
                if (w_i_last_col) begin
                    n_icol = '0;
                    n_irow = r_irow + ROW_W'(1);
                    n_im3  = inc3(r_im3);
                    if (w_i_last_row) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_icol = r_icol + COL_W'(1);
                end
            end
            if (w_emit) begin
                if (w_e_last_col) begin
                    n_ecol = '0;
                    n_erow = r_erow + ROW_W'(1);
                    n_em3  = inc3(r_em3);
                end else begin
                    n_ecol = r_ecol + COL_W'(1);
                end
            end
            n_pend = r_pend + PEND_W'(w_write) - PEND_W'(w_emit);
        end else begin
            // no word taken: positions hold
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol     <= '0;
            r_irow     <= '0;
            r_im3      <= '0;
            r_ecol     <= '0;
            r_erow     <= '0;
            r_em3      <= '0;
            r_pend     <= '0;
            r_done     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_icol     <= n_icol;
            r_irow     <= n_irow;
            r_im3      <= n_im3;
            r_ecol     <= n_ecol;
            r_erow     <= n_erow;
            r_em3      <= n_em3;
            r_pend     <= n_pend;
            r_done     <= n_done;
            r_s1_valid <= w_accept && w_emit;
        end
    end

    // job details ride along with the store read
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_s1_m3    <= r_em3;
            r_s1_byp   <= w_write;
            r_s1_code  <= i_cell_code;
            r_s1_row   <= r_erow;
            r_s1_col   <= r_ecol;
            r_s1_end   <= w_frame_end;
            r_s1_flags <= w_flags;
        end
    end

    // pick rows above, at and below the emitted cell; the newest cell bypasses the store
    assign o_push           = r_s1_valid;
    assign o_job.top        = sel3(r_rd_nxt[0], r_rd_nxt[1], r_rd_nxt[2], dec3(r_s1_m3));
    assign o_job.mid        = sel3(r_rd_nxt[0], r_rd_nxt[1], r_rd_nxt[2], r_s1_m3);
    assign o_job.bot        = r_s1_byp ? r_s1_code
                              : sel3(r_rd_nxt[0], r_rd_nxt[1], r_rd_nxt[2], inc3(r_s1_m3));
    assign o_job.center     = sel3(r_rd_ctr[0], r_rd_ctr[1], r_rd_ctr[2], r_s1_m3);
    assign o_job.row        = r_s1_row;
    assign o_job.col        = r_s1_col;
    assign o_job.frame_end  = r_s1_end;
    assign o_job.flags      = r_s1_flags;

endmodule

// File: rtl/nmf_queue.sv
module nmf_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  nmf_pkg::t_job               i_job,
    input  logic                        i_pop,
    output logic                        o_valid,
    output nmf_pkg::t_job               o_job,
    output logic [nmf_pkg::QCNT_W-1:0]  o_count
);
    import nmf_pkg::*;

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_pop;

    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/nmf_back.sv
module nmf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  nmf_pkg::t_job                 i_job,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_new_code,
    output logic [nmf_pkg::OUT_ROW_W-1:0] o_out_row,
    output logic [nmf_pkg::OUT_COL_W-1:0] o_out_col,
    output logic                          o_frame_end
);
    import nmf_pkg::*;

    localparam int CNT_W = 4;

    logic [CODE_W-1:0] r_win [9];
    logic [CODE_W-1:0] n_win [9];
    logic              r_out_valid;
    logic [CODE_W-1:0] r_code;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_end;

    logic              w_pop;
    logic [CNT_W-1:0]  w_cnt [4];
    logic [1:0]        w_best;
    logic [CODE_W-1:0] w_mode;
    logic [CODE_W-1:0] w_result;

    assign w_pop   = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = w_pop;

    // window slides left, new column enters on the right
    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            n_win[rr*3]     = r_win[rr*3 + 1];
            n_win[rr*3 + 1] = r_win[rr*3 + 2];
        end
        n_win[2] = i_job.top;
        n_win[5] = i_job.mid;
        n_win[8] = i_job.bot;
    end

    // count classes among the usable neighbours
    always_comb begin
        logic use_it;
        for (int j = 0; j < 4; j++) begin
            w_cnt[j] = '0;
        end
        for (int k = 0; k < 9; k++) begin
            use_it = (k != 4);
            if (k / 3 == 0) begin
                use_it = use_it && i_job.flags.top_ok;
            end
            if (k / 3 == 2) begin
                use_it = use_it && i_job.flags.bot_ok;
            end
            if (k % 3 == 0) begin
                use_it = use_it && i_job.flags.left_ok;
            end
            if (k % 3 == 2) begin
                use_it = use_it && i_job.flags.right_ok;
            end
            if (use_it) begin
                unique case (n_win[k])
                    CLS_SAND:  w_cnt[0] = w_cnt[0] + CNT_W'(1);
                    CLS_GRASS: w_cnt[1] = w_cnt[1] + CNT_W'(1);
                    CLS_WATER: w_cnt[2] = w_cnt[2] + CNT_W'(1);
                    CLS_ROCK:  w_cnt[3] = w_cnt[3] + CNT_W'(1);
                    default: ;
                endcase
            end
        end
    end

    // most frequent class, earlier class wins a tie
    always_comb begin
        w_best = 2'd0;
        for (int j = 1; j < 4; j++) begin
            if (w_cnt[j] > w_cnt[w_best]) begin
                w_best = 2'(j);
            end
        end
        unique case (w_best)
            2'd0:    w_mode = CLS_SAND;
            2'd1:    w_mode = CLS_GRASS;
            2'd2:    w_mode = CLS_WATER;
            default: w_mode = CLS_ROCK;
        endcase
    end

    assign w_result = i_job.flags.interior ? w_mode : i_job.center;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_win  <= n_win;
            r_code <= w_result;
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_end  <= i_job.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_code  = r_code;
    assign o_out_row   = OUT_ROW_W'(r_row);
    assign o_out_col   = OUT_COL_W'(r_col);
    assign o_frame_end = r_end;

endmodule

// File: rtl/neighbour_mode_filter_top.sv
// 3x3 mode filter over a raster frame of byte class codes. Cells stream in raster order,
// one word per clock at full rate while the job queue has room; a flush word drains the
// tail of the frame. Border cells come out unchanged, interior cells become the most
// frequent of '.', ':', '~', '&' among their non-border neighbours (earlier class wins
// ties, '.' if none counts). A cell's result leaves frame_width + 1 words after it and
// then passes through the store read, the job queue and the output register; the last
// frame_width + 1 results need flush words. One word per clock is sustained while the
// queue has room because each line-store bank takes one write and its reads in the same
// cycle and the window moves one column per result. frame_width (addr 0x0, 3..128) and
// frame_height (addr 0x4, 3..32) saturate on write, and any write restarts the frame;
// write them only while the block is idle. The line store needs no clearing after reset.
module neighbour_mode_filter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cell words
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_command,
    input  logic [7:0]                       i_cell_code,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_new_code,
    output logic [nmf_pkg::OUT_ROW_W-1:0]    o_out_row,
    output logic [nmf_pkg::OUT_COL_W-1:0]    o_out_col,
    output logic                             o_frame_end,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nmf_pkg::APB_AW-1:0]       paddr,
    input  logic [nmf_pkg::APB_DW-1:0]       pwdata,
    output logic [nmf_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import nmf_pkg::*;

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic              w_cfg_we;
    logic              w_reg_idx;
    logic [FW_W-1:0]   w_fw_raw;
    logic [FH_W-1:0]   w_fh_raw;

    logic              w_push;
    t_job              w_push_job;
    logic              w_q_valid;
    logic              w_q_pop;
    t_job              w_q_job;
    logic [QCNT_W-1:0] w_q_count;

    // register access
    assign pready    = 1'b1;
    assign w_cfg_we  = psel && penable && pwrite;
    assign w_reg_idx = paddr[2];
    assign w_fw_raw  = pwdata[FW_W-1:0];
    assign w_fh_raw  = pwdata[FH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (w_cfg_we) begin
            unique case (w_reg_idx)
                REG_FRAME_WIDTH: begin
                    priority if (32'(w_fw_raw) < 32'(FRAME_MIN)) begin
                        r_frame_width <= FW_W'(FRAME_MIN);
                    end else if (32'(w_fw_raw) > 32'(MAX_COLS)) begin
                        r_frame_width <= FW_W'(MAX_COLS);
                    end else begin
                        r_frame_width <= w_fw_raw;
                    end
                end
                default: begin
                    priority if (32'(w_fh_raw) < 32'(FRAME_MIN)) begin
                        r_frame_height <= FH_W'(FRAME_MIN);
                    end else if (32'(w_fh_raw) > 32'(MAX_ROWS)) begin
                        r_frame_height <= FH_W'(MAX_ROWS);
                    end else begin
                        r_frame_height <= w_fh_raw;
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = APB_DW'(r_frame_width);
        endcase
    end

    // front: takes words, keeps the line store, issues emit jobs
    nmf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (w_cfg_we),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_cell_code    (i_cell_code),
        .i_q_count      (w_q_count),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // job queue
    nmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_count (w_q_count)
    );

    // back: window, class vote and output register
    nmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_job       (w_q_job),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_code  (o_new_code),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end)
    );

endmodule

// File: sim/neighbour_mode_filter_top_tb.sv
`timescale 1ns / 100ps

module neighbour_mode_filter_top_tb;

    import nmf_pkg::*;

    // command codes of a cell word
    localparam logic CMD_FLUSH = ~CMD_CELL;

    // register byte addresses
    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

    // words still to be sent
    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
    } t_cell_word;

    // one filtered cell
    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 fend;
    } t_filt;

    // DUT signals
    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic                    i_command   = CMD_CELL;
    logic [CODE_W-1:0]       i_cell_code = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [CODE_W-1:0]       o_new_code;
    logic [OUT_ROW_W-1:0]    o_out_row;
    logic [OUT_COL_W-1:0]    o_out_col;
    logic                    o_frame_end;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [APB_AW-1:0]       paddr       = '0;
    logic [APB_DW-1:0]       pwdata      = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    neighbour_mode_filter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_cell_code (i_cell_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_new_code  (o_new_code),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // bookkeeping
    t_cell_word cell_word_q[$];
    t_filt      filtered_q[$];
    t_filt      drv_res;
    t_filt      mon_want;
    int         idle_pct      = 31;
    int         err_count     = 0;
    int         words_pushed  = 0;
    int         cells_sent    = 0;
    int         flushes_sent  = 0;
    int         results_seen  = 0;
    int         frames_run    = 0;
    int         settings_run  = 0;

    // filter state mirror
    logic [CODE_W-1:0] line_rows [3][MAX_COLS];
    int cur_w = FW_RESET;
    int cur_h = FH_RESET;
    int wr_row, wr_col, rd_row, rd_col, cells_pending;
    bit frame_loaded;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_frame();
        wr_row        = 0;
        wr_col        = 0;
        rd_row        = 0;
        rd_col        = 0;
        cells_pending = 0;
        frame_loaded  = 1'b0;
    endfunction

    function automatic bit on_edge(input int r, input int c);
        return r == 0 || c == 0 || r + 1 == cur_h || c + 1 == cur_w;
    endfunction

    // next filtered cell in raster order, advancing the read position
    function automatic t_filt emit_filtered();
        int    r;
        int    c;
        int    best;
        int    cnt [4];
        t_filt res;
        r    = rd_row;
        c    = rd_col;
        best = 0;
        for (int k = 0; k < 4; k++) cnt[k] = 0;
        if (on_edge(r, c)) begin
            res.code = line_rows[r % 3][c];
        end else begin
            // count classes over interior neighbours only
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if ((dr != 0 || dc != 0) && !on_edge(r + dr, c + dc)) begin
                        case (line_rows[(r + dr) % 3][c + dc])
                            CLS_SAND:  cnt[0]++;
                            CLS_GRASS: cnt[1]++;
                            CLS_WATER: cnt[2]++;
                            CLS_ROCK:  cnt[3]++;
                            default: ;
                        endcase
                    end
                end
            end
            // strict compare keeps the earlier class on a tie
            for (int k = 1; k < 4; k++) begin
                if (cnt[k] > cnt[best]) best = k;
            end
            case (best)
                0:       res.code = CLS_SAND;
                1:       res.code = CLS_GRASS;
                2:       res.code = CLS_WATER;
                default: res.code = CLS_ROCK;
            endcase
        end
        res.row  = OUT_ROW_W'(r);
        res.col  = OUT_COL_W'(c);
        res.fend = (r + 1 == cur_h) && (c + 1 == cur_w);
        if (res.fend) begin
            clear_frame();
        end else begin
            cells_pending--;
            rd_col++;
            if (rd_col == cur_w) begin
                rd_col = 0;
                rd_row++;
            end
        end
        return res;
    endfunction

    // apply one accepted word; returns 1 when it releases a filtered cell
    function automatic bit filter_word(input logic cmd, input logic [CODE_W-1:0] code,
                                       output t_filt res);
        res = '0;
        if (cmd == CMD_CELL && !frame_loaded) begin
            line_rows[wr_row % 3][wr_col] = code;
            cells_pending++;
            wr_col++;
            if (wr_col == cur_w) begin
                wr_col = 0;
                wr_row++;
                if (wr_row == cur_h) frame_loaded = 1'b1;
            end
            if (cells_pending > cur_w + 1) begin
                res = emit_filtered();
                return 1'b1;
            end
            return 1'b0;
        end
        // flush, or a cell while the tail drains
        if (frame_loaded && cells_pending > 0) begin
            res = emit_filtered();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // mostly class codes, sometimes any byte
    function automatic logic [CODE_W-1:0] rand_code();
        if ($urandom_range(99) >= 75) return CODE_W'($urandom());
        case ($urandom_range(3))
            0:       return CLS_SAND;
            1:       return CLS_GRASS;
            2:       return CLS_WATER;
            default: return CLS_ROCK;
        endcase
    endfunction

    function automatic void push_word(input logic cmd, input logic [CODE_W-1:0] code);
        cell_word_q.push_back('{cmd: cmd, code: code});
        words_pushed++;
    endfunction

    // driver: word source with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_command == CMD_CELL) cells_sent++;
                else flushes_sent++;
                if (filter_word(i_command, i_cell_code, drv_res)) filtered_q.push_back(drv_res);
            end
            if (!i_in_valid || o_in_ready) begin
                if (cell_word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_command   <= cell_word_q[0].cmd;
                    i_cell_code <= cell_word_q[0].code;
                    void'(cell_word_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each filtered cell against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result: code %h row %0d col %0d", o_new_code,
                           o_out_row, o_out_col);
                    err_count++;
                end else begin
                    mon_want = filtered_q.pop_front();
                    results_seen++;
                    if (o_new_code !== mon_want.code) begin
                        $error("new_code: expected %h, got %h", mon_want.code, o_new_code);
                        err_count++;
                    end
                    if (o_out_row !== mon_want.row) begin
                        $error("out_row: expected %0d, got %0d", mon_want.row, o_out_row);
                        err_count++;
                    end
                    if (o_out_col !== mon_want.col) begin
                        $error("out_col: expected %0d, got %0d", mon_want.col, o_out_col);
                        err_count++;
                    end
                    if (o_frame_end !== mon_want.fend) begin
                        $error("frame_end: expected %0d, got %0d", mon_want.fend, o_frame_end);
                        err_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write both registers with junk in the unused bits, then read them back
    task automatic apply_setting(input logic [FW_W-1:0] w_raw, input logic [FH_W-1:0] h_raw);
        logic [APB_DW-1:0] data;
        data            = $urandom();
        data[FW_W-1:0]  = w_raw;
        apb_write(ADDR_FRAME_WIDTH, data);
        cur_w = (int'(w_raw) < FRAME_MIN) ? FRAME_MIN :
                (int'(w_raw) > MAX_COLS) ? MAX_COLS : int'(w_raw);
        clear_frame();
        data            = $urandom();
        data[FH_W-1:0]  = h_raw;
        apb_write(ADDR_FRAME_HEIGHT, data);
        cur_h = (int'(h_raw) < FRAME_MIN) ? FRAME_MIN :
                (int'(h_raw) > MAX_ROWS) ? MAX_ROWS : int'(h_raw);
        clear_frame();
        apb_read(ADDR_FRAME_WIDTH, data);
        if (data[FW_W-1:0] !== FW_W'(cur_w)) begin
            $error("frame_width: expected %0d, got %0d", cur_w, data[FW_W-1:0]);
            err_count++;
        end
        apb_read(ADDR_FRAME_HEIGHT, data);
        if (data[FH_W-1:0] !== FH_W'(cur_h)) begin
            $error("frame_height: expected %0d, got %0d", cur_h, data[FH_W-1:0]);
            err_count++;
        end
        settings_run++;
        @(negedge i_clk);
    endtask

    // all queued words accepted, then all predicted cells returned
    task automatic wait_results();
        while (cell_word_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (filtered_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // quiet enough for a register write
    task automatic wait_idle();
        wait_results();
        repeat (16) @(negedge i_clk);
    endtask

    // one full frame: cells with stray flushes, then the drain words
    task automatic run_frame(input bit pause_mid);
        int total;
        total = cur_w * cur_h;
        for (int k = 0; k < total; k++) begin
            if (pause_mid && k == total / 2) wait_results();
            if ($urandom_range(99) < 4) push_word(CMD_FLUSH, CODE_W'($urandom()));
            push_word(CMD_CELL, rand_code());
        end
        // cells in the drain act as flushes
        for (int k = 0; k <= cur_w; k++) begin
            push_word(($urandom_range(99) < 15) ? CMD_CELL : CMD_FLUSH, CODE_W'($urandom()));
        end
        frames_run++;
    endtask

    // stimulus
    initial begin : stimulus
        int  n;
        bit  paused;
        paused = 1'b0;
        clear_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: partial frame, dropped by the next write
        for (int k = 0; k < 90; k++) push_word(CMD_CELL, rand_code());
        wait_idle();

        // smallest frame: lone interior cell has nothing to count
        apply_setting(8'd0, 6'd1);
        push_word(CMD_CELL, 8'h00);
        push_word(CMD_CELL, 8'hFF);
        push_word(CMD_CELL, CLS_GRASS);
        push_word(CMD_FLUSH, 8'h3C);
        push_word(CMD_CELL, CLS_WATER);
        push_word(CMD_CELL, CLS_ROCK);
        push_word(CMD_CELL, 8'h80);
        push_word(CMD_CELL, CLS_SAND);
        push_word(CMD_CELL, 8'h7F);
        push_word(CMD_CELL, 8'h01);
        push_word(CMD_CELL, 8'hA5);
        push_word(CMD_FLUSH, 8'h00);
        push_word(CMD_CELL, 8'h5A);
        push_word(CMD_FLUSH, 8'hFF);
        push_word(CMD_FLUSH, 8'hC3);
        frames_run++;
        wait_idle();

        // widest rows, saturated from above, without any idling
        idle_pct = 0;
        apply_setting(8'd200, 6'd2);
        run_frame(1'b0);
        wait_idle();
        idle_pct = 31;

        // tallest frame, height saturated from above
        apply_setting(8'd1, 6'd63);
        run_frame(1'b0);
        wait_idle();

        // random small geometries, frames back to back
        while (words_pushed < 880) begin
            if ($urandom_range(7) == 0) apply_setting(FW_W'($urandom_range(13, 40)),
                                                       FH_W'($urandom_range(0, 9)));
            else apply_setting(FW_W'($urandom_range(0, 12)), FH_W'($urandom_range(0, 9)));
            n = $urandom_range(1, 3);
            for (int f = 0; f < n; f++) begin
                run_frame(!paused && f == 0);
                paused = 1'b1;
                if ($urandom_range(2) == 0) push_word(CMD_FLUSH, CODE_W'($urandom()));
            end
            wait_idle();
        end

        // let the pipeline settle and report
        repeat (20) @(negedge i_clk);
        $display("Ran %0d frames over %0d register settings, 3x3 up to 128 wide and 32 tall.",
                 frames_run, settings_run);
        $display("Accepted %0d cell and %0d flush words, checked %0d filtered cells.",
                 cells_sent, flushes_sent, results_seen);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
